// ===== sv/pidpd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidpd_pkg
// Shared types, register codes and Q16.16 saturation helpers for the PID core.
// ----------------------------------------------------------------------------
package pidpd_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int LIM_W     = WORD_W - 1;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;

	// loop modes and commands
	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;
	localparam logic CMD_STEP         = 1'b0;
	localparam logic CMD_CLEAR        = 1'b1;

	typedef logic signed [WORD_W-1:0]   word_t;
	typedef logic        [LIM_W-1:0]    lim_t;
	typedef logic signed [2*WORD_W-1:0] prod_t;
	typedef logic signed [35:0]         wide_t;

	typedef struct packed {
		logic  loop_mode;
		word_t gain_p;
		word_t gain_i;
		word_t gain_d;
		lim_t  output_limit;
		lim_t  integral_limit;
	} cfg_t;

	localparam wide_t WIDE_MAX = 36'sd2147483647;
	localparam wide_t WIDE_MIN = -36'sd2147483648;
	localparam prod_t PROD_MAX = 64'sd2147483647;
	localparam prod_t PROD_MIN = -64'sd2147483648;

	// saturate an exact sum to the signed word range
	function automatic word_t sat_word(input wide_t x);
		word_t r;
		if (x > WIDE_MAX) begin
			r = WIDE_MAX[WORD_W-1:0];
		end else if (x < WIDE_MIN) begin
			r = WIDE_MIN[WORD_W-1:0];
		end else begin
			r = x[WORD_W-1:0];
		end
		return r;
	endfunction

	// drop the fraction bits of a product (floor), then saturate
	function automatic word_t q_scale(input prod_t p);
		prod_t sh;
		word_t r;
		sh = p >>> FRAC_BITS;
		if (sh > PROD_MAX) begin
			r = PROD_MAX[WORD_W-1:0];
		end else if (sh < PROD_MIN) begin
			r = PROD_MIN[WORD_W-1:0];
		end else begin
			r = sh[WORD_W-1:0];
		end
		return r;
	endfunction

	// clamp to plus or minus a non-negative limit
	function automatic word_t clamp_mag(input word_t x, input lim_t lim);
		word_t hi;
		word_t lo;
		word_t r;
		hi = signed'({1'b0, lim});
		lo = -hi;
		if (x > hi) begin
			r = hi;
		end else if (x < lo) begin
			r = lo;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

// ===== sv/pidpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pidpd_cfg_regs
// Write-only configuration registers: loop mode, three gains and two limits.
// ----------------------------------------------------------------------------
module pidpd_cfg_regs
	import pidpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LOOP_MODE:      cfg_q.loop_mode      <= cfg_data[0];
				CFG_GAIN_P:         cfg_q.gain_p         <= signed'(cfg_data);
				CFG_GAIN_I:         cfg_q.gain_i         <= signed'(cfg_data);
				CFG_GAIN_D:         cfg_q.gain_d         <= signed'(cfg_data);
				CFG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_data[LIM_W-1:0];
				CFG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/pidpd_error.sv =====
// ----------------------------------------------------------------------------
// pidpd_error
// Error stage: forms the new error and its first and second differences,
// and keeps the error history.
// ----------------------------------------------------------------------------
module pidpd_error
	import pidpd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  ld_s2,
	input  logic  cmd_s1,
	input  word_t setpoint_s1,
	input  word_t feedback_s1,
	output logic  clr_s2,
	output word_t err_s2,
	output word_t diff1_s2,
	output word_t diff2_s2
);

	word_t err_now_q;
	word_t err_prev_q;
	word_t err_c;
	word_t diff1_c;
	word_t diff2_c;

	// error and its differences against the history
	always_comb begin
		err_c   = sat_word(36'(setpoint_s1) - 36'(feedback_s1));
		diff1_c = sat_word(36'(err_c) - 36'(err_now_q));
		diff2_c = sat_word(36'(err_c) - (36'(err_now_q) <<< 1) + 36'(err_prev_q));
	end

	// history shifts, or clears on a clear command, when an item loads into this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_now_q  <= '0;
			err_prev_q <= '0;
		end else if (ld_s2) begin
			if (cmd_s1 == CMD_CLEAR) begin
				err_now_q  <= '0;
				err_prev_q <= '0;
			end else begin
				err_now_q  <= err_c;
				err_prev_q <= err_now_q;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			clr_s2   <= (cmd_s1 == CMD_CLEAR);
			err_s2   <= err_c;
			diff1_s2 <= diff1_c;
			diff2_s2 <= diff2_c;
		end
	end

endmodule

// ===== sv/pidpd_mult.sv =====
// ----------------------------------------------------------------------------
// pidpd_mult
// Product stage: three gain multiplies, operands chosen by loop mode.
// ----------------------------------------------------------------------------
module pidpd_mult
	import pidpd_pkg::*;
(
	input  logic  clk,
	input  logic  ld_s3,
	input  cfg_t  cfg,
	input  logic  clr_s2,
	input  word_t err_s2,
	input  word_t diff1_s2,
	input  word_t diff2_s2,
	output logic  clr_s3,
	output prod_t prod_p_s3,
	output prod_t prod_i_s3,
	output prod_t prod_d_s3
);

	word_t op_p;
	word_t op_d;

	// positional uses the error and first difference, incremental shifts one order up
	always_comb begin
		if (cfg.loop_mode == MODE_INCREMENTAL) begin
			op_p = diff1_s2;
			op_d = diff2_s2;
		end else begin
			op_p = err_s2;
			op_d = diff1_s2;
		end
	end

	// raw products, scaled in the next stage
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			clr_s3    <= clr_s2;
			prod_p_s3 <= cfg.gain_p * op_p;
			prod_i_s3 <= cfg.gain_i * err_s2;
			prod_d_s3 <= cfg.gain_d * op_d;
		end
	end

endmodule

// ===== sv/pidpd_accum.sv =====
// ----------------------------------------------------------------------------
// pidpd_accum
// Scaling, partial sum, integral accumulator and output clamp.
// ----------------------------------------------------------------------------
module pidpd_accum
	import pidpd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  ld_s4,
	input  logic  ld_s5,
	input  cfg_t  cfg,
	input  logic  clr_s3,
	input  prod_t prod_p_s3,
	input  prod_t prod_i_s3,
	input  prod_t prod_d_s3,
	output word_t drive
);

	logic               clr_s4;
	logic signed [33:0] presum_s4;
	word_t              term_i_s4;
	word_t              integral_q;
	word_t              last_q;

	word_t              term_p;
	word_t              term_i;
	word_t              term_d;
	logic signed [33:0] presum_c;
	word_t              integral_c;
	word_t              sum_c;

	// scale products and add the terms that do not feed back
	always_comb begin
		term_p   = q_scale(prod_p_s3);
		term_i   = q_scale(prod_i_s3);
		term_d   = q_scale(prod_d_s3);
		presum_c = 34'(term_p) + 34'(term_d);
		if (cfg.loop_mode == MODE_INCREMENTAL) begin
			presum_c = presum_c + 34'(term_i);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			clr_s4    <= clr_s3;
			presum_s4 <= presum_c;
			term_i_s4 <= term_i;
		end
	end

	// accumulator update and final sum
	always_comb begin
		if (cfg.loop_mode == MODE_INCREMENTAL) begin
			integral_c = term_i_s4;
			sum_c      = sat_word(36'(last_q) + 36'(presum_s4));
		end else begin
			integral_c = clamp_mag(sat_word(36'(integral_q) + 36'(term_i_s4)),
				cfg.integral_limit);
			sum_c      = sat_word(36'(presum_s4) + 36'(integral_c));
		end
	end

	// last output doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			last_q     <= '0;
		end else if (ld_s5) begin
			if (clr_s4) begin
				integral_q <= '0;
				last_q     <= '0;
			end else begin
				integral_q <= integral_c;
				last_q     <= clamp_mag(sum_c, cfg.output_limit);
			end
		end
	end

	assign drive = last_q;

endmodule

// ===== sv/pid_position_or_delta.sv =====
// ----------------------------------------------------------------------------
// pid_position_or_delta
// Discrete PID controller, positional or incremental, signed Q16.16.
//
//  channel  | signals                        | payload
//  ---------+--------------------------------+---------------------------------
//  input    | s_tvalid s_tready s_tdata      | setpoint [31:0], feedback [63:32]
//           | s_tuser                        | command (1 = clear all state)
//  output   | m_tvalid m_tready m_tdata      | drive_out [31:0]
//  config   | cfg_wr_en cfg_index cfg_data   | register index, write data
//
// One item per cycle while the output is not stalled.
// Five stages: input, error, multiply, scale and partial sum, accumulate.
// The integral and last-output feedback closes inside the accumulate stage.
// Each stage moves on when the next one is empty or moving, so bubbles fill
// while the output is stalled. Reset clears valids, state and registers.
// ----------------------------------------------------------------------------
module pid_position_or_delta
	import pidpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*WORD_W-1:0]  s_tdata,   // setpoint, feedback
	input  logic                 s_tuser,   // command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [WORD_W-1:0]    m_tdata,   // drive_out
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	cfg_t  cfg;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic  rdy1, rdy2, rdy3, rdy4, rdy5;
	logic  ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
	logic  cmd_s1;
	word_t setpoint_s1, feedback_s1;
	logic  clr_s2, clr_s3;
	word_t err_s2, diff1_s2, diff2_s2;
	prod_t prod_p_s3, prod_i_s3, prod_d_s3;
	word_t drive;

	// stage ready chain
	always_comb begin
		rdy5  = !v_s5 || m_tready;
		rdy4  = !v_s4 || rdy5;
		rdy3  = !v_s3 || rdy4;
		rdy2  = !v_s2 || rdy3;
		rdy1  = !v_s1 || rdy2;
		ld_s1 = s_tvalid && rdy1;
		ld_s2 = v_s1 && rdy2;
		ld_s3 = v_s2 && rdy3;
		ld_s4 = v_s3 && rdy4;
		ld_s5 = v_s4 && rdy5;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			cmd_s1      <= s_tuser;
			setpoint_s1 <= signed'(s_tdata[WORD_W-1:0]);
			feedback_s1 <= signed'(s_tdata[2*WORD_W-1:WORD_W]);
		end
	end

	pidpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidpd_error u_error (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld_s2       (ld_s2),
		.cmd_s1      (cmd_s1),
		.setpoint_s1 (setpoint_s1),
		.feedback_s1 (feedback_s1),
		.clr_s2      (clr_s2),
		.err_s2      (err_s2),
		.diff1_s2    (diff1_s2),
		.diff2_s2    (diff2_s2)
	);

	pidpd_mult u_mult (
		.clk       (clk),
		.ld_s3     (ld_s3),
		.cfg       (cfg),
		.clr_s2    (clr_s2),
		.err_s2    (err_s2),
		.diff1_s2  (diff1_s2),
		.diff2_s2  (diff2_s2),
		.clr_s3    (clr_s3),
		.prod_p_s3 (prod_p_s3),
		.prod_i_s3 (prod_i_s3),
		.prod_d_s3 (prod_d_s3)
	);

	pidpd_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_s4     (ld_s4),
		.ld_s5     (ld_s5),
		.cfg       (cfg),
		.clr_s3    (clr_s3),
		.prod_p_s3 (prod_p_s3),
		.prod_i_s3 (prod_i_s3),
		.prod_d_s3 (prod_d_s3),
		.drive     (drive)
	);

	assign s_tready = rdy1;
	assign m_tvalid = v_s5;
	assign m_tdata  = drive;

endmodule

// ===== sv/pidpd_checker.sv =====
// ----------------------------------------------------------------------------
// pidpd_checker
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidpd_checker
	import pidpd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [WORD_W-1:0]    m_tdata,
	input logic                 cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [WORD_W-1:0]    cfg_data
);

	lim_t out_lim_q;
	logic signed [WORD_W:0] drive_ext;
	logic signed [WORD_W:0] lim_ext;

	// shadow of the output limit seen on the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_lim_q <= '0;
		end else if (cfg_wr_en && cfg_index == CFG_OUTPUT_LIMIT) begin
			out_lim_q <= cfg_data[LIM_W-1:0];
		end
	end

	assign drive_ext = (WORD_W+1)'(signed'(m_tdata));
	assign lim_ext   = signed'({2'b00, out_lim_q});

	// a stalled result stays and holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// every result lies inside the output clamp
	a_out_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (drive_ext <= lim_ext) && (drive_ext >= -lim_ext))
		else $error("result outside output limit");

	// with the output empty the pipeline has room
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output empty");

	// no result right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result shown after reset");

endmodule

bind pid_position_or_delta pidpd_checker u_pidpd_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional / incremental PID core. A driver
// offers queued control items on the input stream, a monitor predicts each
// drive value in Q16.16 and checks the output stream in order. Gains, limits
// and loop mode are changed between phases while the core is idle, and the
// phases vary input idling and output stalls, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_top
	import pidpd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// config indexes past the last register, ignored by the core
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_CAP   = 30;

	typedef struct {
		logic  cmd;
		word_t sp;
		word_t fb;
	} ctl_item_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [2*WORD_W-1:0]  s_tdata   = '0;   // setpoint, feedback
	logic                 s_tuser   = 1'b0; // command
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [WORD_W-1:0]    m_tdata;          // drive_out
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;

	ctl_item_t ctl_pending[$];
	word_t     drive_due[$];
	int        mismatch_count = 0;
	int        src_idle_pct   = 0;
	int        dst_stall_pct  = 0;
	bit        hold_tog       = 1'b0;
	bit        hold_seen      = 1'b0;
	int        hold_cnt       = 0;

	// controller mirror: registers and loop state
	logic   mode_r;
	longint kp, ki, kd, out_lim, int_lim;
	longint err0, err1, err2, integ_acc, last_drive;

	pid_position_or_delta dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// saturate to the signed word range
	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// gain times value, floor of the fraction bits, saturated
	function automatic longint qprod(longint g, longint v);
		longint p;
		p = g * v;
		return sat32(p >>> FRAC_BITS);
	endfunction

	function automatic longint clamp_lim(longint x, longint lim);
		if (x > lim) return lim;
		if (x < -lim) return -lim;
		return x;
	endfunction

	// advance the loop state by one control item, return the drive value
	function automatic word_t predict_drive(logic cmd, word_t sp, word_t fb);
		longint p, i, d, y;
		if (cmd == CMD_CLEAR) begin
			err0       = 0;
			err1       = 0;
			err2       = 0;
			integ_acc  = 0;
			last_drive = 0;
			return '0;
		end
		err2 = err1;
		err1 = err0;
		err0 = sat32(longint'(sp) - longint'(fb));
		if (mode_r == MODE_POSITIONAL) begin
			p         = qprod(kp, err0);
			integ_acc = clamp_lim(sat32(integ_acc + qprod(ki, err0)), int_lim);
			d         = qprod(kd, sat32(err0 - err1));
			y         = sat32(p + integ_acc + d);
		end else begin
			p         = qprod(kp, sat32(err0 - err1));
			i         = qprod(ki, err0);
			integ_acc = i;
			d         = qprod(kd, sat32(err0 - 2 * err1 + err2));
			y         = sat32(last_drive + p + i + d);
		end
		last_drive = clamp_lim(y, out_lim);
		return word_t'(last_drive[WORD_W-1:0]);
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
	endtask

	// input driver: present the next queued item once the current one is taken
	always @(posedge clk or negedge arst_n) begin : drv
		ctl_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (ctl_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt      = ctl_pending.pop_front();
				s_tdata  <= {nxt.fb, nxt.sp};
				s_tuser  <= nxt.cmd;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready: random stalls, or a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_cnt  <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= dst_stall_pct);
		end
	end

	// monitor: check output transfers, then predict from input transfers
	always @(posedge clk) begin : mon
		word_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (drive_due.size() == 0) begin
					report_mismatch("unexpected drive_out", m_tdata, '0);
				end else begin
					want = drive_due.pop_front();
					if (m_tdata !== want)
						report_mismatch("drive_out", m_tdata, want);
				end
			end
			if (s_tvalid && s_tready)
				drive_due.push_back(predict_drive(s_tuser, s_tdata[WORD_W-1:0],
					s_tdata[2*WORD_W-1:WORD_W]));
		end
	end

	task automatic push_item(logic cmd, word_t sp, word_t fb);
		ctl_item_t it;
		it.cmd = cmd;
		it.sp  = sp;
		it.fb  = fb;
		ctl_pending.push_back(it);
	endtask

	// wait until every item is taken and every drive value has come back
	task automatic drain();
		while (ctl_pending.size() != 0 || s_tvalid || drive_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_LOOP_MODE:      mode_r  = data[0];
			CFG_GAIN_P:         kp      = longint'(signed'(data));
			CFG_GAIN_I:         ki      = longint'(signed'(data));
			CFG_GAIN_D:         kd      = longint'(signed'(data));
			CFG_OUTPUT_LIMIT:   out_lim = longint'(data[LIM_W-1:0]);
			CFG_INTEGRAL_LIMIT: int_lim = longint'(data[LIM_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic apply_cfg(logic mode, word_t gp, word_t gi, word_t gd,
			logic [WORD_W-1:0] olim, logic [WORD_W-1:0] ilim);
		write_reg(CFG_LOOP_MODE, {31'd0, mode});
		write_reg(CFG_GAIN_P, gp);
		write_reg(CFG_GAIN_I, gi);
		write_reg(CFG_GAIN_D, gd);
		write_reg(CFG_OUTPUT_LIMIT, olim);
		write_reg(CFG_INTEGRAL_LIMIT, ilim);
		@(negedge clk);
	endtask

	task automatic set_idling(int sel);
		case (sel)
			0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
			1: begin src_idle_pct = 58; dst_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  dst_stall_pct = 58; end
			default: begin src_idle_pct = 36; dst_stall_pct = 36; end
		endcase
	endtask

	// mostly moderate values, sometimes full range or the extremes
	function automatic word_t rand_val();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom();
			default: return word_t'(int'($urandom_range(4194304)) - 2097152);
		endcase
	endfunction

	function automatic word_t rand_gain();
		case ($urandom_range(6))
			0: return word_t'(int'($urandom_range(524288)) - 262144);
			1: return $urandom();
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return '0;
			default: return word_t'(int'($urandom_range(32768)) - 16384 + 65536);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_lim();
		case ($urandom_range(4))
			0: return '0;
			1: return {1'($urandom_range(1)), 31'h7FFF_FFFF};
			2: return $urandom();
			default: return $urandom_range(32'h0400_0000, 32'h0001_0000);
		endcase
	endfunction

	// runs with a held setpoint and a tracking feedback, some noise and clears
	task automatic run_random_phase(int n);
		word_t sp;
		word_t fb;
		int    k;
		sp = rand_val();
		for (k = 0; k < n; k++) begin
			if ($urandom_range(99) < 3) begin
				push_item(CMD_CLEAR, $urandom(), $urandom());
			end else begin
				if ($urandom_range(99) < 15)
					sp = rand_val();
				if ($urandom_range(99) < 70)
					fb = sp - word_t'(int'($urandom_range(131072)) - 65536);
				else
					fb = rand_val();
				push_item(CMD_STEP, sp, fb);
			end
		end
	endtask

	initial begin : stim
		int ph;
		mode_r     = MODE_POSITIONAL;
		kp         = 0;
		ki         = 0;
		kd         = 0;
		out_lim    = 0;
		int_lim    = 0;
		err0       = 0;
		err1       = 0;
		err2       = 0;
		integ_acc  = 0;
		last_drive = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: positional with moderate gains, error extremes and clears
		write_reg(CFG_SPARE_LO, $urandom());
		write_reg(CFG_SPARE_HI, $urandom());
		apply_cfg(MODE_POSITIONAL, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
			32'hFFFF_FFFF, 32'h0100_0000);
		push_item(CMD_CLEAR, 32'h1234_5678, 32'h9ABC_DEF0);
		push_item(CMD_STEP, '0, '0);
		push_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(CMD_STEP, 32'h0001_0000, '0);
		push_item(CMD_STEP, '0, 32'h0001_0000);
		push_item(CMD_STEP, 32'hFFFF_FFFF, '0);
		push_item(CMD_STEP, 32'h1234_5678, 32'h0F0F_0F0F);
		push_item(CMD_CLEAR, '0, '0);
		push_item(CMD_STEP, 32'h0005_0000, 32'h0002_0000);
		push_item(CMD_STEP, 32'h0005_0000, 32'h0002_0000);
		drain();

		// incremental with a zero output limit, then a small one, and a zero integral limit
		apply_cfg(MODE_INCREMENTAL, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000,
			32'h0000_0000, 32'h0000_0000);
		push_item(CMD_STEP, 32'h0003_0000, '0);
		push_item(CMD_STEP, 32'h0006_0000, '0);
		drain();
		write_reg(CFG_OUTPUT_LIMIT, 32'h0010_0000);
		@(negedge clk);
		push_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(CMD_STEP, '0, '0);
		push_item(CMD_STEP, 32'h0002_0000, 32'h0001_0000);
		drain();

		// back to positional: integral carries over from incremental mode
		write_reg(CFG_LOOP_MODE, {31'd0, MODE_POSITIONAL});
		@(negedge clk);
		push_item(CMD_STEP, 32'h0002_0000, 32'h0001_0000);
		push_item(CMD_CLEAR, '0, '0);
		push_item(CMD_STEP, 32'h0002_0000, 32'h0001_0000);
		drain();

		// long output hold-off while the input keeps offering
		set_idling(0);
		apply_cfg(MODE_INCREMENTAL, rand_gain(), rand_gain(), rand_gain(),
			rand_lim(), rand_lim());
		run_random_phase(40);
		hold_tog = ~hold_tog;
		drain();

		// random phases over settings and idling patterns
		for (ph = 0; ph < 12; ph++) begin
			set_idling(ph % 4);
			case (ph)
				0: apply_cfg(MODE_POSITIONAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				1: apply_cfg(MODE_INCREMENTAL, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
				2: apply_cfg(MODE_INCREMENTAL, 32'h7FFF_FFFF, 32'h0000_0000,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				3: apply_cfg(MODE_POSITIONAL, 32'h8000_0000, 32'h0001_0000,
					32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
				default: apply_cfg(1'($urandom_range(1)), rand_gain(), rand_gain(),
					rand_gain(), rand_lim(), rand_lim());
			endcase
			run_random_phase(124);
			drain();
		end

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
sv/pidpd_pkg.sv
sv/pidpd_cfg_regs.sv
sv/pidpd_error.sv
sv/pidpd_mult.sv
sv/pidpd_accum.sv
sv/pid_position_or_delta.sv
sv/pidpd_checker.sv
tb/tb_top.sv
